FILE: rtl/ekui_pkg.sv
// Package for the encoder knob controller: event, turn, press and action codes,
// the configuration and result structs, and level limits.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
`default_nettype none

package ekui_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int TICK_W      = 32;
  localparam int LEVEL_W     = 7;
  localparam int FREQ_W      = 4;
  localparam int COUNT_W     = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
  localparam logic [LEVEL_W-1:0] BRIGHT_STEP = 7'd1;
  localparam logic [LEVEL_W-1:0] FAN_STEP    = 7'd5;
  localparam logic [FREQ_W-1:0]  FREQ_TOP    = 4'd15;

  typedef enum logic [1:0] {
    OP_STEP = 2'd0,
    OP_RISE = 2'd1,
    OP_FALL = 2'd2,
    OP_POLL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_UP   = 2'd1,
    TURN_DOWN = 2'd2
  } turn_t;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_PAUSE  = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHORT_PRESS = 8'd0,
    REG_LONG_PRESS  = 8'd1,
    REG_MAX_PRESS   = 8'd2,
    REG_FREQ_COUNT  = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] short_press_ticks;
    logic [CFG_DATA_W-1:0] long_press_ticks;
    logic [CFG_DATA_W-1:0] max_press_ticks;
    logic [COUNT_W-1:0]    freq_option_count;
  } cfg_t;

  typedef struct packed {
    action_t             action;
    logic [LEVEL_W-1:0]  brightness;
    logic [LEVEL_W-1:0]  fan_pct;
    logic [FREQ_W-1:0]   freq_index;
    logic                menu_mode;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ekui_if.sv
// Valid/ready channel interfaces of the encoder knob controller: events in,
// results out, and configuration writes. Depends on ekui_pkg for widths.
`default_nettype none

interface ekui_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic                         turn_up;
  logic [ekui_pkg::TICK_W-1:0]  now_ticks;

  modport source (output valid, opcode, turn_up, now_ticks, input ready);
  modport sink   (input valid, opcode, turn_up, now_ticks, output ready);
endinterface

interface ekui_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [ekui_pkg::LEVEL_W-1:0]  brightness;
  logic [ekui_pkg::LEVEL_W-1:0]  fan_pct;
  logic [ekui_pkg::FREQ_W-1:0]   freq_index;
  logic                          menu_mode;

  modport source (output valid, action, brightness, fan_pct, freq_index, menu_mode,
                  input ready);
  modport sink   (input valid, action, brightness, fan_pct, freq_index, menu_mode,
                  output ready);
endinterface

interface ekui_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ekui_pkg::CFG_INDEX_W-1:0]  index;
  logic [ekui_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/encoder_knob_ui_controller.sv
// Encoder knob UI controller, top level: event input register, event core and
// result register. Depends on ekui_pkg, the channel interfaces, ekui_cfg, ekui_core.
// A result is registered in the result register after its event leaves the event input register.
// Throughput: one event per cycle while the result channel is not stalled.
// Reset (synchronous, rst high) clears all UI state, empties both stages and loads
// the configuration reset values; the block is ready in the cycle after reset.
`default_nettype none

module encoder_knob_ui_controller (
  input  wire logic  clk,
  input  wire logic  rst,
  ekui_in_if.sink    evt,
  ekui_out_if.source res,
  ekui_cfg_if.sink   cfg
);

  logic                          ev_vld;
  logic [1:0]                    ev_opcode;
  logic                          ev_turn_up;
  logic [ekui_pkg::TICK_W-1:0]   ev_now;
  logic                          out_vld;
  ekui_pkg::res_t                out_res;
  ekui_pkg::res_t                res_next;
  ekui_pkg::cfg_t                regs;
  logic                          advance;
  logic                          go;

  // The event stage moves on whenever the result register is free or being drained.
  assign advance   = !out_vld || res.ready;
  assign go        = ev_vld && advance;
  assign evt.ready = !ev_vld || advance;

  ekui_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ekui_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .opcode    (ev_opcode),
    .turn_up   (ev_turn_up),
    .now_ticks (ev_now),
    .regs      (regs),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld <= 1'b0;
    end else if (evt.ready) begin
      ev_vld <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      ev_opcode  <= evt.opcode;
      ev_turn_up <= evt.turn_up;
      ev_now     <= evt.now_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= ev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res <= res_next;
    end
  end

  assign res.valid      = out_vld;
  assign res.action     = out_res.action;
  assign res.brightness = out_res.brightness;
  assign res.fan_pct    = out_res.fan_pct;
  assign res.freq_index = out_res.freq_index;
  assign res.menu_mode  = out_res.menu_mode;

endmodule

`default_nettype wire

FILE: rtl/ekui_cfg.sv
// Configuration register bank of the encoder knob controller.
// Depends on ekui_pkg and the ekui_cfg_if interface.
`default_nettype none

module ekui_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  ekui_cfg_if.sink      cfg,
  output ekui_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_press_ticks <= 16'd500;
      regs.long_press_ticks  <= 16'd1000;
      regs.max_press_ticks   <= 16'd5000;
      regs.freq_option_count <= 5'd4;
    end else if (cfg.valid) begin
      // Writes to indexes past the last register are dropped.
      unique case (ekui_pkg::reg_index_t'(cfg.index))
        ekui_pkg::REG_SHORT_PRESS: regs.short_press_ticks <= cfg.data;
        ekui_pkg::REG_LONG_PRESS:  regs.long_press_ticks  <= cfg.data;
        ekui_pkg::REG_MAX_PRESS:   regs.max_press_ticks   <= cfg.data;
        ekui_pkg::REG_FREQ_COUNT:
          regs.freq_option_count <= cfg.data[ekui_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ekui_core.sv
// Event processing and UI state of the encoder knob controller: turn, press and
// level registers, with the next result computed from one registered event.
// Depends on ekui_pkg.
`default_nettype none

module ekui_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [1:0]                   opcode,
  input  wire logic                         turn_up,
  input  wire logic [ekui_pkg::TICK_W-1:0]  now_ticks,
  input  wire ekui_pkg::cfg_t               regs,
  output ekui_pkg::res_t                    res_next
);

  ekui_pkg::turn_t                 pending_turn, pending_turn_next;
  logic [ekui_pkg::TICK_W-1:0]     press_start, press_start_next;
  logic                            button_held, button_held_next;
  ekui_pkg::press_t                pending_press, pending_press_next;
  logic                            skip_release, skip_release_next;
  logic                            menu_flag, menu_flag_next;
  logic [ekui_pkg::LEVEL_W-1:0]    bright_level, bright_level_next;
  logic [ekui_pkg::LEVEL_W-1:0]    fan_level, fan_level_next;
  logic [ekui_pkg::FREQ_W-1:0]     freq_level, freq_level_next;
  ekui_pkg::action_t               action;

  logic [ekui_pkg::TICK_W-1:0]     press_len;
  ekui_pkg::press_t                press_class;
  logic [ekui_pkg::COUNT_W-1:0]    freq_plus;
  logic                            dir_up;
  logic [ekui_pkg::LEVEL_W:0]      bright_sum, fan_sum;

  assign press_len = now_ticks - press_start;
  assign dir_up    = (pending_turn == ekui_pkg::TURN_UP);
  assign freq_plus = {1'b0, freq_level} + 5'd1;
  assign bright_sum = {1'b0, bright_level} + {1'b0, ekui_pkg::BRIGHT_STEP};
  assign fan_sum    = {1'b0, fan_level} + {1'b0, ekui_pkg::FAN_STEP};

  always_comb begin
    if (press_len < {16'd0, regs.short_press_ticks}) begin
      press_class = ekui_pkg::PRESS_SHORT;
    end else if (press_len > {16'd0, regs.long_press_ticks} &&
                 press_len < {16'd0, regs.max_press_ticks}) begin
      press_class = ekui_pkg::PRESS_LONG;
    end else begin
      press_class = ekui_pkg::PRESS_NONE;
    end
  end

  always_comb begin
    pending_turn_next  = pending_turn;
    press_start_next   = press_start;
    button_held_next   = button_held;
    pending_press_next = pending_press;
    skip_release_next  = skip_release;
    menu_flag_next     = menu_flag;
    bright_level_next  = bright_level;
    fan_level_next     = fan_level;
    freq_level_next    = freq_level;
    action             = ekui_pkg::ACT_NONE;

    unique case (ekui_pkg::opcode_t'(opcode))
      ekui_pkg::OP_STEP: begin
        pending_turn_next = turn_up ? ekui_pkg::TURN_UP : ekui_pkg::TURN_DOWN;
      end
      ekui_pkg::OP_RISE: begin
        press_start_next = now_ticks;
        button_held_next = 1'b1;
      end
      ekui_pkg::OP_FALL: begin
        if (!skip_release) begin
          pending_press_next = press_class;
        end
        press_start_next  = '0;
        button_held_next  = 1'b0;
        skip_release_next = 1'b0;
      end
      ekui_pkg::OP_POLL: begin
        if (pending_turn != ekui_pkg::TURN_NONE) begin
          if (button_held) begin
            // A turn while held retunes the frequency and cancels the press.
            skip_release_next = 1'b1;
            if (dir_up) begin
              if (freq_plus < regs.freq_option_count && freq_level != ekui_pkg::FREQ_TOP) begin
                freq_level_next = freq_plus[ekui_pkg::FREQ_W-1:0];
              end
            end else if (freq_level != '0) begin
              freq_level_next = freq_level - 4'd1;
            end
          end else if (menu_flag) begin
            if (dir_up) begin
              if (bright_sum <= {1'b0, ekui_pkg::LEVEL_MAX}) begin
                bright_level_next = bright_sum[ekui_pkg::LEVEL_W-1:0];
              end
            end else if (bright_level >= ekui_pkg::BRIGHT_STEP) begin
              bright_level_next = bright_level - ekui_pkg::BRIGHT_STEP;
            end
          end else begin
            if (dir_up) begin
              if (fan_sum <= {1'b0, ekui_pkg::LEVEL_MAX}) begin
                fan_level_next = fan_sum[ekui_pkg::LEVEL_W-1:0];
              end
            end else if (fan_level >= ekui_pkg::FAN_STEP) begin
              fan_level_next = fan_level - ekui_pkg::FAN_STEP;
            end
          end
          pending_turn_next = ekui_pkg::TURN_NONE;
          action            = ekui_pkg::ACT_UPDATE;
        end else if (pending_press == ekui_pkg::PRESS_SHORT) begin
          menu_flag_next     = !menu_flag;
          pending_press_next = ekui_pkg::PRESS_NONE;
        end else if (pending_press == ekui_pkg::PRESS_LONG) begin
          pending_press_next = ekui_pkg::PRESS_NONE;
          action             = ekui_pkg::ACT_PAUSE;
        end
      end
      default: ;
    endcase
  end

  assign res_next.action     = action;
  assign res_next.brightness = bright_level_next;
  assign res_next.fan_pct    = fan_level_next;
  assign res_next.freq_index = freq_level_next;
  assign res_next.menu_mode  = menu_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_turn  <= ekui_pkg::TURN_NONE;
      press_start   <= '0;
      button_held   <= 1'b0;
      pending_press <= ekui_pkg::PRESS_NONE;
      skip_release  <= 1'b0;
      menu_flag     <= 1'b0;
      bright_level  <= '0;
      fan_level     <= '0;
      freq_level    <= '0;
    end else if (go) begin
      pending_turn  <= pending_turn_next;
      press_start   <= press_start_next;
      button_held   <= button_held_next;
      pending_press <= pending_press_next;
      skip_release  <= skip_release_next;
      menu_flag     <= menu_flag_next;
      bright_level  <= bright_level_next;
      fan_level     <= fan_level_next;
      freq_level    <= freq_level_next;
    end
  end

endmodule

`default_nettype wire

FILE: bench/ekui_tb_pkg.sv
// Scoreboard for the encoder knob controller bench: tracks the UI state and the
// register settings, and holds the results still owed by the block.
// Depends on ekui_pkg for the event, turn, press, action and register codes.
`timescale 1ns / 100ps

package ekui_tb_pkg;
  import ekui_pkg::*;

  class knob_scoreboard;
    logic [CFG_DATA_W-1:0] short_lim;
    logic [CFG_DATA_W-1:0] long_lim;
    logic [CFG_DATA_W-1:0] max_lim;
    logic [COUNT_W-1:0]    freq_count;

    turn_t               turn_dir;
    logic [TICK_W-1:0]   press_t0;
    bit                  held;
    bit                  skip_fall;
    bit                  menu_on;
    press_t              press_kind;
    logic [LEVEL_W-1:0]  bright_lvl;
    logic [LEVEL_W-1:0]  fan_lvl;
    logic [FREQ_W-1:0]   freq_lvl;

    res_t owed_q[$];
    int   errors;
    int   events_seen;
    int   results_seen;

    function new();
      short_lim   = 16'd500;
      long_lim    = 16'd1000;
      max_lim     = 16'd5000;
      freq_count  = 5'd4;
      turn_dir    = TURN_NONE;
      press_t0    = '0;
      held        = 1'b0;
      skip_fall   = 1'b0;
      menu_on     = 1'b0;
      press_kind  = PRESS_NONE;
      bright_lvl  = '0;
      fan_lvl     = '0;
      freq_lvl    = '0;
      errors      = 0;
      events_seen = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SHORT_PRESS: short_lim = value;
        REG_LONG_PRESS:  long_lim = value;
        REG_MAX_PRESS:   max_lim = value;
        REG_FREQ_COUNT:  freq_count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function press_t classify(logic [TICK_W-1:0] len);
      if (len < short_lim) return PRESS_SHORT;
      if (len > long_lim && len < max_lim) return PRESS_LONG;
      return PRESS_NONE;
    endfunction

    // A step that would leave 0..100 leaves the level where it is.
    function logic [LEVEL_W-1:0] nudge(logic [LEVEL_W-1:0] lvl, logic [LEVEL_W-1:0] stp,
                                       bit up);
      if (up) begin
        if (int'(lvl) + int'(stp) <= int'(LEVEL_MAX)) return lvl + stp;
      end else if (lvl >= stp) begin
        return lvl - stp;
      end
      return lvl;
    endfunction

    function void note_event(opcode_t op, bit up, logic [TICK_W-1:0] now);
      res_t    r;
      action_t act;
      act = ACT_NONE;
      case (op)
        OP_STEP: turn_dir = up ? TURN_UP : TURN_DOWN;
        OP_RISE: begin
          press_t0 = now;
          held = 1'b1;
        end
        OP_FALL: begin
          if (!skip_fall) press_kind = classify(now - press_t0);
          press_t0 = '0;
          held = 1'b0;
          skip_fall = 1'b0;
        end
        OP_POLL: begin
          if (turn_dir != TURN_NONE) begin
            if (held) begin
              // Turning while held changes the frequency and cancels the press.
              skip_fall = 1'b1;
              if (turn_dir == TURN_UP) begin
                if (int'(freq_lvl) + 1 < int'(freq_count) && int'(freq_lvl) + 1 < 16)
                  freq_lvl++;
              end else if (freq_lvl != 0) begin
                freq_lvl--;
              end
            end else if (menu_on) begin
              bright_lvl = nudge(bright_lvl, BRIGHT_STEP, turn_dir == TURN_UP);
            end else begin
              fan_lvl = nudge(fan_lvl, FAN_STEP, turn_dir == TURN_UP);
            end
            turn_dir = TURN_NONE;
            act = ACT_UPDATE;
          end else if (press_kind == PRESS_SHORT) begin
            menu_on = !menu_on;
            press_kind = PRESS_NONE;
          end else if (press_kind == PRESS_LONG) begin
            press_kind = PRESS_NONE;
            act = ACT_PAUSE;
          end
        end
        default: ;
      endcase
      r.action     = act;
      r.brightness = bright_lvl;
      r.fan_pct    = fan_lvl;
      r.freq_index = freq_lvl;
      r.menu_mode  = menu_on;
      owed_q.push_back(r);
      events_seen++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] act, logic [LEVEL_W-1:0] bright,
                               logic [LEVEL_W-1:0] fan, logic [FREQ_W-1:0] freq,
                               logic menu);
      res_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: action %0d", act);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("action", want.action, act);
      compare_field("brightness", want.brightness, bright);
      compare_field("fan_pct", want.fan_pct, fan);
      compare_field("freq_index", want.freq_index, freq);
      compare_field("menu_mode", want.menu_mode, menu);
    endfunction
  endclass

endpackage

FILE: bench/encoder_knob_ui_controller_tb.sv
// Bench top for encoder_knob_ui_controller: directed and random knob, button and
// poll requests under several register settings, with bursty input and stalled output.
// Depends on ekui_pkg, the channel interfaces and the scoreboard in ekui_tb_pkg.
`timescale 1ns / 100ps

module encoder_knob_ui_controller_tb;
  import ekui_pkg::*;
  import ekui_tb_pkg::*;

  localparam int RANDOM_EVENTS   = 1550;
  localparam int PHASES          = 7;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam logic [CFG_INDEX_W-1:0] BAD_REG_INDEX = 8'hFC;

  logic clk;
  logic rst;

  ekui_in_if  evt_if ();
  ekui_out_if res_if ();
  ekui_cfg_if cfg_if ();

  encoder_knob_ui_controller u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  knob_scoreboard knob_sb;

  int events_sent;
  int burst_left;
  int gap_max;
  int idle_cycles;
  int settings_done;
  int ready_tick;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor and watchdog: everything is sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_if.valid && evt_if.ready)
        knob_sb.note_event(opcode_t'(evt_if.opcode), evt_if.turn_up, evt_if.now_ticks);
      if (res_if.valid && res_if.ready)
        knob_sb.check_result(res_if.action, res_if.brightness, res_if.fan_pct,
                             res_if.freq_index, res_if.menu_mode);
      if (cfg_if.valid && cfg_if.ready)
        knob_sb.set_reg(cfg_if.index, cfg_if.data);
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: a rotating stall pattern, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    ready_tick = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        res_if.ready <= 1'b1;
      end else begin
        ready_tick++;
        case ((ready_tick / 97) % 4)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(1, 0) == 0);
          2: res_if.ready <= ($urandom_range(3, 0) == 0);
          default: res_if.ready <= ((ready_tick % 5) < 3);
        endcase
      end
    end
  end

  // Holds one request on the event channel until it is taken. Requests go out in
  // bursts; between bursts the channel sits idle for a random number of cycles.
  task automatic offer_event(opcode_t op, bit up, logic [TICK_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        evt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    evt_if.valid     <= 1'b1;
    evt_if.opcode    <= op;
    evt_if.turn_up   <= up;
    evt_if.now_ticks <= now;
    do @(posedge clk); while (!evt_if.ready);
    events_sent++;
  endtask

  task automatic send_reg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] short_v, logic [CFG_DATA_W-1:0] long_v,
                                logic [CFG_DATA_W-1:0] max_v, logic [CFG_DATA_W-1:0] count_v);
    send_reg_write(REG_SHORT_PRESS, short_v);
    send_reg_write(REG_LONG_PRESS, long_v);
    send_reg_write(REG_MAX_PRESS, max_v);
    send_reg_write(REG_FREQ_COUNT, count_v);
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  // Lets every owed result come back before the registers are touched.
  task automatic drain();
    evt_if.valid <= 1'b0;
    burst_left = 0;
    while (knob_sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A full press: rise, optional turns while held, fall at a length picked around
  // the current thresholds, then the poll that reports it.
  task automatic press_episode();
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] len;
    int n_turns;
    int up_odds;
    t0 = $urandom;
    case ($urandom_range(9, 0))
      0: len = knob_sb.short_lim - 32'd1;
      1: len = knob_sb.short_lim;
      2: len = knob_sb.long_lim;
      3: len = knob_sb.long_lim + 32'd1;
      4: len = knob_sb.max_lim - 32'd1;
      5: len = knob_sb.max_lim;
      6: len = $urandom_range(knob_sb.short_lim, 0);
      7: len = $urandom_range(knob_sb.max_lim, knob_sb.long_lim);
      8: len = $urandom;
      default: len = $urandom_range(70000, 0);
    endcase
    offer_event(OP_RISE, $urandom_range(1, 0), t0);
    n_turns = 0;
    if ($urandom_range(3, 0) == 0)
      n_turns = ($urandom_range(3, 0) == 0) ? $urandom_range(18, 10) : $urandom_range(4, 1);
    up_odds = $urandom_range(3, 1);
    repeat (n_turns) begin
      offer_event(OP_STEP, $urandom_range(3, 0) < up_odds, $urandom);
      offer_event(OP_POLL, $urandom_range(1, 0), $urandom);
    end
    if ($urandom_range(7, 0) == 0) offer_event(OP_POLL, $urandom_range(1, 0), $urandom);
    offer_event(OP_FALL, $urandom_range(1, 0), t0 + len);
    // A turn waiting at the poll takes precedence over the press.
    if ($urandom_range(4, 0) == 0) offer_event(OP_STEP, $urandom_range(1, 0), $urandom);
    offer_event(OP_POLL, $urandom_range(1, 0), $urandom);
  endtask

  task automatic turn_run();
    int  n;
    bit  dir_up;
    dir_up = $urandom_range(1, 0);
    n = ($urandom_range(7, 0) == 0) ? $urandom_range(110, 60) : $urandom_range(12, 1);
    repeat (n) begin
      if ($urandom_range(5, 0) == 0) offer_event(OP_STEP, !dir_up, $urandom);
      offer_event(OP_STEP, dir_up, $urandom);
      offer_event(OP_POLL, $urandom_range(1, 0), $urandom);
    end
  endtask

  task automatic random_events(int n);
    int goal;
    int pick;
    goal = events_sent + n;
    while (events_sent < goal) begin
      pick = $urandom_range(9, 0);
      if (pick < 4)
        press_episode();
      else if (pick < 8)
        turn_run();
      else
        repeat ($urandom_range(4, 1))
          offer_event(opcode_t'($urandom_range(3, 0)), $urandom_range(1, 0), $urandom);
    end
  endtask

  initial begin
    knob_sb = new();
    events_sent   = 0;
    burst_left    = 0;
    gap_max       = 6;
    idle_cycles   = 0;
    settings_done = 1;
    hold_off_req  = 1'b0;
    rst <= 1'b1;
    evt_if.valid     <= 1'b0;
    evt_if.opcode    <= OP_STEP;
    evt_if.turn_up   <= 1'b0;
    evt_if.now_ticks <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_SHORT_PRESS;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests on the reset settings.
    offer_event(OP_POLL, 1'b1, 32'd0);
    // Last direction wins; fan already at zero, so down is clamped.
    offer_event(OP_STEP, 1'b1, 32'hFFFF_FFFF);
    offer_event(OP_STEP, 1'b0, 32'd0);
    offer_event(OP_POLL, 1'b0, 32'd0);
    offer_event(OP_STEP, 1'b1, 32'd5);
    offer_event(OP_POLL, 1'b0, 32'd6);
    // A fall with no rise measures from zero: a short press toggles the menu.
    offer_event(OP_FALL, 1'b0, 32'd100);
    offer_event(OP_POLL, 1'b0, 32'd101);
    offer_event(OP_STEP, 1'b1, 32'd102);
    offer_event(OP_POLL, 1'b1, 32'd103);
    // Press across the tick wrap, long enough to request a pause.
    offer_event(OP_RISE, 1'b1, 32'hFFFF_FF00);
    offer_event(OP_FALL, 1'b1, 32'h0000_0400);
    offer_event(OP_POLL, 1'b0, 32'd0);
    // Between the short and long thresholds: no press.
    offer_event(OP_RISE, 1'b0, 32'd0);
    offer_event(OP_FALL, 1'b0, 32'd700);
    offer_event(OP_POLL, 1'b0, 32'd701);
    // Turns while held step the frequency and suppress the release.
    offer_event(OP_RISE, 1'b0, 32'd10);
    offer_event(OP_STEP, 1'b1, 32'd11);
    offer_event(OP_POLL, 1'b0, 32'd12);
    offer_event(OP_STEP, 1'b0, 32'd13);
    offer_event(OP_POLL, 1'b0, 32'd14);
    offer_event(OP_FALL, 1'b0, 32'd20);
    offer_event(OP_POLL, 1'b1, 32'd21);

    random_events(RANDOM_EVENTS / PHASES);

    drain();
    send_reg_write(BAD_REG_INDEX, 16'hFFFF);
    apply_settings(16'd1, 16'd1, 16'd2, 16'hFFF0);
    // The output holds off while requests keep coming, so the block backs up.
    hold_off_req = 1'b1;
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    gap_max = 0;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    gap_max = 12;
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    apply_settings(16'd300, 16'd400, 16'd2000, 16'h001F);
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    gap_max = 8;
    apply_settings($urandom_range(3000, 1), $urandom_range(5000, 3000),
                   $urandom_range(12000, 5000), $urandom_range(16, 1));
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    gap_max = 4;
    apply_settings(16'd500, 16'd1000, 16'd5000, 16'd4);
    random_events(RANDOM_EVENTS / PHASES);

    drain();
    knob_sb.errors += knob_sb.owed_q.size();
    $display("Run covered %0d knob/button/poll requests and %0d checked results",
             knob_sb.events_seen, knob_sb.results_seen);
    $display("over %0d register settings, with bursty input and a %0d-cycle output hold-off.",
             settings_done, HOLD_OFF_CYCLES);
    if (knob_sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
